// ===== hw/rtl/edf_pkg.sv =====
`default_nettype none

package edf_pkg;

   localparam int TASK_ID_BITS        = 6;
   localparam int TASK_COUNT          = 1 << TASK_ID_BITS;
   localparam int DEADLINE_BITS       = 32;
   localparam int COUNT_OUT_BITS      = 5;
   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int CSR_DATA_BITS       = 32;
   localparam int CSR_ADDR_BITS       = 3;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_IDLE_TASK = 1'b0;

   typedef enum logic [1:0] {
      MODE_ENQUEUE  = 2'd0,
      MODE_DEQUEUE  = 2'd1,
      MODE_ACTIVATE = 2'd2,
      MODE_QUERY    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_IGNORED = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      mode_type                  mode;
      logic [TASK_ID_BITS-1:0]   task_id;
      logic [DEADLINE_BITS-1:0]  deadline;
   } req_type;

   typedef struct packed {
      logic [TASK_ID_BITS-1:0]   next_task;
      logic [DEADLINE_BITS-1:0]  next_deadline;
      logic                      next_is_idle;
      logic [COUNT_OUT_BITS-1:0] queue_count;
      status_type                status;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic place;
      logic commit;
   } dp_cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/edf_ready_queue.sv =====
`default_nettype none

// Earliest-deadline-first ready queue. Task ids are kept in a table sorted by
// ascending deadline, with one membership bit per task id; each request item
// (enqueue, dequeue, activate, query) returns one response item with the head
// of the queue, or the idle task when the queue is empty, plus the count and a
// status code. From acceptance to response each item steps through: accept,
// compare the deadline and id against all table entries in parallel,
// priority-encode the insert or remove position, then shift the table and
// load the response register. The commit step waits while an earlier response
// has not been taken, and a new request is accepted only once the previous one
// has committed. Nothing needs clearing after reset. The idle task id is set
// through the register port at byte address 0.
module edf_ready_queue #(
   parameter int QUEUE_DEPTH = edf_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire edf_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output edf_pkg::rsp_type                       rsp_data,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [edf_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [edf_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [edf_pkg::CSR_DATA_BITS-1:0]      prdata,
   output logic                                   pready
);
   import edf_pkg::*;

   logic [TASK_ID_BITS-1:0] idle_task_ff, idle_task_in;
   dp_cmd_type              cmd;

   assign pready = 1'b1;

   always_comb begin
      idle_task_in = idle_task_ff;
      if (psel && penable && pwrite && paddr[2] == CSR_IDX_IDLE_TASK) begin
         idle_task_in = pwdata[TASK_ID_BITS-1:0];
      end
      prdata = '0;
      if (paddr[2] == CSR_IDX_IDLE_TASK) begin
         prdata[TASK_ID_BITS-1:0] = idle_task_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_task_ff <= '0;
      end else begin
         idle_task_ff <= idle_task_in;
      end
   end

   edf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   edf_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .idle_task (idle_task_ff),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/edf_ctrl.sv =====
`default_nettype none

module edf_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output edf_pkg::dp_cmd_type     cmd
);
   import edf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            state_in = ST_PLACE;
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold the update until the result register can take the item
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/edf_datapath.sv =====
`default_nettype none

module edf_datapath #(
   parameter int QUEUE_DEPTH = edf_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire edf_pkg::dp_cmd_type             cmd,
   input  wire edf_pkg::req_type                req_data,
   input  wire logic [edf_pkg::TASK_ID_BITS-1:0] idle_task,
   output edf_pkg::rsp_type                     rsp_data
);
   import edf_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   req_type                  item_ff;
   logic [TASK_ID_BITS-1:0]  ids_ff [QUEUE_DEPTH];
   logic [TASK_ID_BITS-1:0]  ids_in [QUEUE_DEPTH];
   logic [DEADLINE_BITS-1:0] dls_ff [QUEUE_DEPTH];
   logic [DEADLINE_BITS-1:0] dls_in [QUEUE_DEPTH];
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [TASK_COUNT-1:0]    member_ff, member_in;
   logic                     cur_valid_ff, cur_valid_in;
   logic [DEADLINE_BITS-1:0] cur_dl_ff, cur_dl_in;
   logic [DEADLINE_BITS-1:0] idle_dl_ff, idle_dl_in;

   logic [QUEUE_DEPTH-1:0]   sel_ff, sel_in;
   logic [QUEUE_DEPTH-1:0]   eq_ff, eq_in;
   logic [QUEUE_DEPTH-1:0]   hit_ff, hit_in;
   status_type               status_ff, status_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic                     found_ff, found_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     enq_ok, deq_ok;
   logic [CNT_W+COUNT_OUT_BITS-1:0] count_wide;

   assign rsp_data = rsp_ff;

   // per-entry compares, all entries in parallel
   always_comb begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         logic live;
         live      = CNT_W'(j) < count_ff;
         sel_in[j] = live && (item_ff.deadline <= dls_ff[j]);
         eq_in[j]  = live && (item_ff.deadline == dls_ff[j]);
         hit_in[j] = live && (item_ff.task_id == ids_ff[j]);
      end
      status_in = STATUS_DONE;
      unique case (item_ff.mode)
         MODE_ENQUEUE: begin
            if (member_ff[item_ff.task_id] || item_ff.task_id == idle_task) begin
               status_in = STATUS_IGNORED;
            end else if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
               status_in = STATUS_FULL;
            end
         end
         MODE_DEQUEUE: begin
            if (!member_ff[item_ff.task_id] || item_ff.task_id == idle_task) begin
               status_in = STATUS_IGNORED;
            end
         end
         default: status_in = STATUS_DONE;
      endcase
   end

   // first matching entry wins: scan from the top so lower indexes overwrite
   always_comb begin
      pos_in   = count_ff[IDX_W-1:0];
      found_in = 1'b0;
      for (int j = QUEUE_DEPTH - 1; j >= 0; j--) begin
         if (item_ff.mode == MODE_ENQUEUE) begin
            if (sel_ff[j]) begin
               // equal deadline goes right after that entry
               pos_in = IDX_W'(j) + IDX_W'(eq_ff[j]);
            end
         end else if (hit_ff[j]) begin
            pos_in   = IDX_W'(j);
            found_in = 1'b1;
         end
      end
   end

   assign enq_ok = cmd.commit && item_ff.mode == MODE_ENQUEUE && status_ff == STATUS_DONE;
   assign deq_ok = cmd.commit && item_ff.mode == MODE_DEQUEUE && status_ff == STATUS_DONE;

   always_comb begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         ids_in[k] = ids_ff[k];
         dls_in[k] = dls_ff[k];
         if (enq_ok) begin
            if (IDX_W'(k) == pos_ff) begin
               ids_in[k] = item_ff.task_id;
               dls_in[k] = item_ff.deadline;
            end else if (k > 0 && IDX_W'(k) > pos_ff) begin
               ids_in[k] = ids_ff[(k > 0) ? k - 1 : 0];
               dls_in[k] = dls_ff[(k > 0) ? k - 1 : 0];
            end
         end else if (deq_ok && found_ff) begin
            if (k < QUEUE_DEPTH - 1 && IDX_W'(k) >= pos_ff) begin
               ids_in[k] = ids_ff[(k < QUEUE_DEPTH - 1) ? k + 1 : k];
               dls_in[k] = dls_ff[(k < QUEUE_DEPTH - 1) ? k + 1 : k];
            end
         end
      end

      count_in  = count_ff;
      member_in = member_ff;
      if (enq_ok) begin
         count_in                   = count_ff + CNT_W'(1);
         member_in[item_ff.task_id] = 1'b1;
      end else if (deq_ok) begin
         member_in[item_ff.task_id] = 1'b0;
         if (found_ff) begin
            count_in = count_ff - CNT_W'(1);
         end
      end

      cur_valid_in = cur_valid_ff;
      cur_dl_in    = cur_dl_ff;
      if (cmd.commit && item_ff.mode == MODE_ACTIVATE) begin
         cur_valid_in = 1'b1;
         cur_dl_in    = item_ff.deadline;
      end

      idle_dl_in = idle_dl_ff;
      if (cmd.commit && item_ff.mode == MODE_QUERY && count_ff == '0 && cur_valid_ff) begin
         idle_dl_in = cur_dl_ff;
      end

      // result reflects the table after this item
      count_wide = {{COUNT_OUT_BITS{1'b0}}, count_in};
      if (count_in != '0) begin
         rsp_in.next_task     = ids_in[0];
         rsp_in.next_deadline = dls_in[0];
         rsp_in.next_is_idle  = 1'b0;
      end else begin
         rsp_in.next_task     = idle_task;
         rsp_in.next_deadline = idle_dl_in;
         rsp_in.next_is_idle  = 1'b1;
      end
      rsp_in.queue_count = count_wide[COUNT_OUT_BITS-1:0];
      rsp_in.status      = status_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.scan) begin
         sel_ff    <= sel_in;
         eq_ff     <= eq_in;
         hit_ff    <= hit_in;
         status_ff <= status_in;
      end
      if (cmd.place) begin
         pos_ff   <= pos_in;
         found_ff <= found_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
         for (int k = 0; k < QUEUE_DEPTH; k++) begin
            ids_ff[k] <= ids_in[k];
            dls_ff[k] <= dls_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         member_ff    <= '0;
         cur_valid_ff <= 1'b0;
         cur_dl_ff    <= '0;
         idle_dl_ff   <= '0;
      end else begin
         count_ff     <= count_in;
         member_ff    <= member_in;
         cur_valid_ff <= cur_valid_in;
         cur_dl_ff    <= cur_dl_in;
         idle_dl_ff   <= idle_dl_in;
      end
   end

endmodule

`default_nettype wire
